// File: src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// Motor feedback frame decoder package
// Shared constants, register codes and the frame descriptor type.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // Frame layout: bytes 0 to 8 are stored, byte 9 is the check byte.
  localparam int FRAME_STORE = 9;
  localparam int BYTE_IDX_W  = $clog2(FRAME_STORE + 1);
  localparam logic [BYTE_IDX_W-1:0] CHECK_INDEX = BYTE_IDX_W'(FRAME_STORE);

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_FORMAT = 2'd1;
  localparam logic [7:0] CRC_POLY_RESET = 8'h8C;

  // Default depth of the queue between the byte front end and the decode back end.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Position scaling, full circle is 360 degrees in Q9.7.
  localparam logic [15:0] POS_FULL_Q7 = 16'd46080;
  // Standard frame: round(n * 46080 / 32767) = floor((n * 46080 + 16383) / 32767).
  localparam logic [15:0] STD_MUL     = 16'd46080;
  localparam logic [14:0] STD_ROUND   = 15'd16383;
  localparam logic [16:0] STD_DIV     = 17'd32767;
  localparam logic [16:0] STD_DIV2    = 17'd65534;
  localparam logic [15:0] STD_NEG_OFS = 16'd32769;
  // Extended frame: round(b * 3072 / 17) = floor((b * 3072 + 8) / 17), and the
  // division by 17 is an exact multiply by ceil(2^24 / 17) over this range.
  localparam logic [19:0] EXT_ROUND   = 20'd8;
  localparam logic [19:0] EXT_RECIP   = 20'd986896;

  typedef struct packed {
    logic            crc_ok;
    logic            ext_format;
    logic [8:0][7:0] bytes;
  } mfd_frame_t;

endpackage

// File: src/mfd_front.sv
// ----------------------------------------------------------------------------
// Motor feedback frame decoder, byte front end
// Takes received bytes, folds them into the CRC, stores the frame and hands
// a complete frame to the queue on its check byte.
// ----------------------------------------------------------------------------
module mfd_front import mfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             frame_reset,
  input  logic [7:0]       crc_polynomial,
  input  logic             feedback_format,
  input  logic             queue_full,
  output logic             push,
  output mfd_frame_t       push_frame
);

  logic [BYTE_IDX_W-1:0] byte_count;
  logic [7:0]            running_crc;
  logic [7:0]            frame_bytes [FRAME_STORE];

  logic                  accept;
  logic [BYTE_IDX_W-1:0] eff_count;
  logic [7:0]            eff_crc;
  logic [7:0]            crc_next;

  // Reflected CRC-8, one data bit per step, LSB first.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc_in,
                                          input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int b = 0; b < 8; b++) begin
      mix = crc[0] ^ data[b];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ poly;
      end
    end
    return crc;
  endfunction

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign eff_count = frame_reset ? '0 : byte_count;
  assign eff_crc   = frame_reset ? '0 : running_crc;
  assign crc_next  = crc_fold(eff_crc, rx_byte, crc_polynomial);
  assign push      = accept && (eff_count >= CHECK_INDEX);

  always_comb begin
    push_frame.crc_ok     = (rx_byte == eff_crc);
    push_frame.ext_format = feedback_format;
    for (int i = 0; i < FRAME_STORE; i++) begin
      push_frame.bytes[i] = frame_bytes[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= '0;
    end else if (accept) begin
      if (eff_count < CHECK_INDEX) begin
        byte_count  <= eff_count + 1'b1;
        running_crc <= crc_next;
      end else begin
        byte_count  <= '0;
        running_crc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (eff_count < CHECK_INDEX)) begin
      frame_bytes[eff_count] <= rx_byte;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CHECK_INDEX)
    else $error("byte counter ran past the check byte");

endmodule

// File: src/mfd_queue.sv
// ----------------------------------------------------------------------------
// Motor feedback frame decoder, frame queue
// Short first-in first-out queue of complete frames between front and back.
// ----------------------------------------------------------------------------
module mfd_queue import mfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  mfd_frame_t push_frame,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output mfd_frame_t head_frame
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mfd_frame_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_frame = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("frame pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("frame popped from an empty queue");

endmodule

// File: src/mfd_back.sv
// ----------------------------------------------------------------------------
// Motor feedback frame decoder, decode back end
// Two-stage pipeline: scales the position by constant reciprocals and
// drives the registered result word.
// ----------------------------------------------------------------------------
module mfd_back import mfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mfd_frame_t         head_frame,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               crc_ok,
  output logic [7:0]         motor_id,
  output logic [7:0]         motor_mode,
  output logic signed [15:0] current_raw,
  output logic signed [15:0] velocity_raw,
  output logic [15:0]        position_deg_q7,
  output logic [7:0]         temperature,
  output logic [7:0]         fault_byte
);

  logic        s1_valid;
  mfd_frame_t  s1_frame;
  logic [30:0] s1_std_y;
  logic [39:0] s1_ext_prod;

  logic        out_free;
  logic        s1_adv;
  logic [15:0] raw_pos;
  logic [15:0] raw_wrapped;
  logic [14:0] std_n;
  logic [30:0] std_y;
  logic [19:0] ext_v;
  logic [39:0] ext_prod;
  logic [15:0] std_q0;
  logic [16:0] std_r0;
  logic [15:0] std_pos;
  logic [15:0] ext_pos;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign pop      = head_valid && (!s1_valid || s1_adv);

  // Stage 1: negative positions wrap by a full turn. The most negative code
  // is the only one still negative after the wrap, and it saturates to zero.
  always_comb begin
    raw_pos     = {head_frame.bytes[6], head_frame.bytes[7]};
    raw_wrapped = raw_pos - STD_NEG_OFS;
    std_n       = raw_pos[15] ? (raw_wrapped[15] ? 15'd0 : raw_wrapped[14:0])
                              : raw_pos[14:0];
    std_y       = 31'(std_n) * 31'(STD_MUL) + 31'(STD_ROUND);
    ext_v       = 20'({head_frame.bytes[7], 11'b0}) + 20'({head_frame.bytes[7], 10'b0})
                  + EXT_ROUND;
    ext_prod    = ext_v * EXT_RECIP;
  end

  // Stage 2: divide by 32767 as a shift by 15 plus the carried quotient,
  // then at most two correction steps.
  always_comb begin
    std_q0  = s1_std_y[30:15];
    std_r0  = {2'b0, s1_std_y[14:0]} + {1'b0, std_q0};
    std_pos = std_q0 + 16'(std_r0 >= STD_DIV) + 16'(std_r0 >= STD_DIV2);
    ext_pos = s1_ext_prod[39:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_frame    <= head_frame;
      s1_std_y    <= std_y;
      s1_ext_prod <= ext_prod;
    end
    if (s1_adv) begin
      crc_ok          <= s1_frame.crc_ok;
      motor_id        <= s1_frame.bytes[0];
      motor_mode      <= s1_frame.bytes[1];
      current_raw     <= {s1_frame.bytes[2], s1_frame.bytes[3]};
      velocity_raw    <= {s1_frame.bytes[4], s1_frame.bytes[5]};
      position_deg_q7 <= s1_frame.ext_format ? ext_pos : std_pos;
      temperature     <= s1_frame.ext_format ? s1_frame.bytes[6] : 8'd0;
      fault_byte      <= s1_frame.bytes[8];
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (position_deg_q7 <= POS_FULL_Q7))
    else $error("decoded position beyond a full turn");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stalled decode stage lost its frame");

endmodule

// File: src/motor_feedback_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// Motor feedback frame decoder
// Decodes 10-byte motor feedback frames with a CRC-8 check and scaled position.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock on the input channel while
// the frame queue has room, and produces one result word for every tenth
// byte of a frame, carrying the CRC check, the raw frame fields and the
// position in Q9.7 degrees. Throughput is one byte per cycle, set by the
// byte front end, which folds a whole byte into the reflected CRC-8 at once.
// After its check byte is accepted, a frame is written into the frame queue,
// leaves it into the multiply stage and has its quotient corrected into the
// output register. The frame queue holds QUEUE_DEPTH complete frames, so
// the front end keeps taking bytes while the output waits; only when the
// queue is full does the input see ready low. Setting frame_reset with a
// byte drops any partial frame and makes that byte the first of a new one.
// The two configuration registers are written through their own channel,
// which is always ready; a write to an unknown index is ignored. The
// polynomial is applied to each byte as it is taken, and the frame format
// is sampled with the check byte.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder_top import mfd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Received byte channel.
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             rx_byte,
  input  logic                   frame_reset,
  // Decoded frame channel.
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   crc_ok,
  output logic [7:0]             motor_id,
  output logic [7:0]             motor_mode,
  output logic signed [15:0]     current_raw,
  output logic signed [15:0]     velocity_raw,
  output logic [15:0]            position_deg_q7,
  output logic [7:0]             temperature,
  output logic [7:0]             fault_byte,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0] polynomial;
  logic       feedback_format;
  logic       queue_full;
  logic       push;
  mfd_frame_t push_frame;
  logic       pop;
  logic       head_valid;
  mfd_frame_t head_frame;

  // The configuration registers take every write in the cycle it is offered.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial      <= CRC_POLY_RESET;
      feedback_format <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CRC_POLYNOMIAL: begin
          polynomial <= cfg_data[7:0];
        end
        REG_FEEDBACK_FORMAT: begin
          feedback_format <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front end folds bytes into the CRC and stores the frame; on the
  // check byte it pushes the whole frame into the queue.
  mfd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .frame_reset     (frame_reset),
    .crc_polynomial  (polynomial),
    .feedback_format (feedback_format),
    .queue_full      (queue_full),
    .push            (push),
    .push_frame      (push_frame)
  );

  mfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  // The back end scales the position and holds the result word until it is
  // taken, independent of the byte stream.
  mfd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_frame      (head_frame),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .crc_ok          (crc_ok),
    .motor_id        (motor_id),
    .motor_mode      (motor_mode),
    .current_raw     (current_raw),
    .velocity_raw    (velocity_raw),
    .position_deg_q7 (position_deg_q7),
    .temperature     (temperature),
    .fault_byte      (fault_byte)
  );

  // A cycle in reset always leaves the polynomial register at its reset value.
  a_poly_reset: assert property (@(posedge clk)
    rst |=> (polynomial == CRC_POLY_RESET))
    else $error("polynomial register not at its reset value");

endmodule

// File: tb/motor_feedback_frame_decoder_top_test.sv
// ----------------------------------------------------------------------------
// Motor feedback frame decoder testbench
// Streams feedback frames through the decoder and checks every result word.
// ----------------------------------------------------------------------------
// A stimulus process feeds received bytes through the valid/ready input
// channel. A tracker keeps its own copy of the frame state, taking every byte
// that is accepted. On each check byte it predicts the decoded word: the
// CRC-8 verdict, the raw fields and the scaled position. A checker compares
// every accepted result word with the oldest prediction, field by field.
// The run opens with a table of hand-picked frames. These cover position
// extremes in both formats, good and bad check bytes, and dropped partial
// frames. They also cover polynomial and format changes in the middle of a
// frame. Random phases follow, each with its own register setting and its
// own idle pattern. One phase stalls the result side long enough to fill the
// block's frame queue. Another lets the sender pause until every result has
// drained.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfd_pkg::*;

  // Register indexes that map to nothing; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  localparam int ITEM_TARGET     = 1550;
  localparam int IDLE_MAX        = 12;
  localparam int LONG_HOLD       = 200;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NO_TAG          = -1;
  // Register changes inside a frame land after this many bytes.
  localparam int MID_FRAME_POINT = 5;

  // Position scaling: a full turn is 360 degrees, 46080 in Q9.7.
  localparam longint TURN_Q7  = 46080;
  localparam longint STD_SPAN = 32767;
  localparam longint EXT_SPAN = 255;

  typedef enum logic [1:0] {
    CHECK_GOOD,
    CHECK_BAD
  } check_kind_t;

  // One decoded frame as it should leave the block.
  typedef struct packed {
    logic               crc_ok;
    logic [7:0]         id;
    logic [7:0]         mode;
    logic signed [15:0] current;
    logic signed [15:0] velocity;
    logic [15:0]        position;
    logic [7:0]         temp;
    logic [7:0]         fault;
  } frame_result_t;

  // A hand-picked frame. The body holds bytes 0 to 8, byte 0 in the top bits.
  // Junk bytes go out first and are then dropped by frame_reset. A mid-frame
  // value of -1 means no register change. Wanted crc or position of -1 means
  // the tracker's prediction is used for that field.
  typedef struct packed {
    logic        fmt;
    logic [7:0]  poly;
    logic [71:0] body;
    check_kind_t kind;
    int          junk;
    int          mid_poly;
    int          mid_fmt;
    int          want_crc;
    int          want_pos;
  } directed_frame_t;

  localparam int DIRECTED_COUNT = 11;
  localparam directed_frame_t DIRECTED_FRAMES [DIRECTED_COUNT] = '{
    // All zero: zero CRC, zero position.
    '{1'b0, 8'h8C, 72'h0, CHECK_GOOD, 0, -1, -1, 1, 0},
    // Largest positive position is a full turn.
    '{1'b0, 8'h8C, 72'hFF_FF_FFFF_FFFF_7FFF_FF, CHECK_GOOD, 0, -1, -1, 1, 46080},
    // Most negative position saturates to zero; check byte is wrong.
    '{1'b0, 8'h8C, 72'h01_02_8000_7FFF_8000_00, CHECK_BAD, 0, -1, -1, 0, 0},
    // Minus one wraps to just under a full turn; current and velocity extremes.
    '{1'b0, 8'h8C, 72'h12_34_7FFF_8000_FFFF_A5, CHECK_GOOD, 0, -1, -1, 1, 46079},
    // Minus 32767 wraps to exactly zero.
    '{1'b0, 8'h8C, 72'h7E_81_1234_EDCB_8001_5A, CHECK_BAD, 0, -1, -1, 0, 0},
    // Extended frame with the largest temperature and position.
    '{1'b1, 8'h8C, 72'hC3_3C_0F0F_F0F0_FFFF_FF, CHECK_GOOD, 0, -1, -1, 1, 46080},
    // Extended frame at zero.
    '{1'b1, 8'h8C, 72'h80_7F_0000_0000_0000_80, CHECK_BAD, 0, -1, -1, 0, 0},
    // A zero polynomial.
    '{1'b1, 8'h00, 72'h55_AA_55AA_55AA_55AA_55, CHECK_GOOD, 0, -1, -1, -1, -1},
    // A partial frame dropped by frame_reset, with an all-ones polynomial.
    '{1'b0, 8'hFF, 72'hA5_5A_0102_0304_4000_AA, CHECK_GOOD, 4, -1, -1, -1, -1},
    // Format switched to standard in mid frame; it is sampled at the check byte.
    '{1'b1, 8'h8C, 72'h33_44_9988_7766_2211_F0, CHECK_GOOD, 0, -1, 0, -1, -1},
    // Polynomial switched in mid frame; each byte folds with its own.
    '{1'b0, 8'h8C, 72'h9A_BC_DEF0_1357_2468_0F, CHECK_GOOD, 0, 49, -1, 1, -1}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               frame_reset = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               crc_ok;
  logic [7:0]         motor_id;
  logic [7:0]         motor_mode;
  logic signed [15:0] current_raw;
  logic signed [15:0] velocity_raw;
  logic [15:0]        position_deg_q7;
  logic [7:0]         temperature;
  logic [7:0]         fault_byte;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Travels with each byte word so the tracker knows which table row it is.
  int in_tag = NO_TAG;

  // Register values as the block should hold them.
  logic [7:0] poly_shadow = CRC_POLY_RESET;
  logic       fmt_shadow = 1'b0;

  // Frame state of the tracker.
  logic [BYTE_IDX_W-1:0] tracked_count = '0;
  logic [7:0]            tracked_crc = 8'h00;
  logic [7:0]            tracked_bytes [FRAME_STORE];

  frame_result_t expected_frames [$];

  int mismatch_count = 0;
  int sent_bytes = 0;
  int src_idle_max = IDLE_MAX;
  int sink_idle_max = IDLE_MAX;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sink_gap = 0;
  int quiet_cycles = 0;

  motor_feedback_frame_decoder_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .frame_reset     (frame_reset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .crc_ok          (crc_ok),
    .motor_id        (motor_id),
    .motor_mode      (motor_mode),
    .current_raw     (current_raw),
    .velocity_raw    (velocity_raw),
    .position_deg_q7 (position_deg_q7),
    .temperature     (temperature),
    .fault_byte      (fault_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-8, one data bit at a time, least significant bit first.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic mix;
    int   k;
    for (k = 0; k < 8; k++) begin
      mix = crc[0] ^ data[k];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ poly;
      end
    end
    return crc;
  endfunction

  // Position in Q9.7 degrees, rounded to nearest. In the standard format a
  // negative reading is wrapped by a full turn, and the one reading that is
  // still negative after the wrap is held at zero.
  function automatic logic [15:0] scaled_position(input logic ext, input logic [7:0] hi,
                                                  input logic [7:0] lo);
    logic [15:0] raw;
    longint      n;
    raw = {hi, lo};
    if (ext) begin
      return 16'((longint'(lo) * 2 * TURN_Q7 + EXT_SPAN) / (2 * EXT_SPAN));
    end
    if (raw == 16'h8000) begin
      return 16'h0000;
    end
    n = raw[15] ? longint'(raw) - 32769 : longint'(raw);
    return 16'((n * 2 * TURN_Q7 + STD_SPAN) / (2 * STD_SPAN));
  endfunction

  function automatic int idle_choice();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return IDLE_MAX;
    endcase
  endfunction

  task automatic compare_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Offers one byte word after a random idle gap and waits until it is taken.
  task automatic put_byte(input logic [7:0] value, input logic restart, input int row_tag);
    int gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= value;
    frame_reset <= restart;
    in_tag      <= row_tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Stops offering bytes and waits until every predicted word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
  endtask

  // Registers change only while the block is idle. A partial frame may still
  // be in flight, so the write is held back after the last word to let it settle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index == REG_CRC_POLYNOMIAL) begin
      poly_shadow = value;
    end else if (index == REG_FEEDBACK_FORMAT) begin
      fmt_shadow = value[0];
    end
  endtask

  // Sends bytes 0 to 8 and a check byte. The sender keeps its own running CRC
  // so that a good check byte is right even when the polynomial changes
  // inside the frame; a bad one differs from it in at least one bit.
  task automatic send_frame(input logic [71:0] body, input check_kind_t kind,
                            input logic restart, input int row_tag,
                            input int mid_poly, input int mid_fmt);
    logic [7:0] running;
    logic [7:0] value;
    logic [7:0] check;
    int         k;
    running = 8'h00;
    for (k = 0; k < FRAME_STORE; k++) begin
      if (k == MID_FRAME_POINT && mid_poly >= 0) begin
        write_reg(REG_CRC_POLYNOMIAL, mid_poly[7:0]);
      end
      if (k == MID_FRAME_POINT && mid_fmt >= 0) begin
        write_reg(REG_FEEDBACK_FORMAT, mid_fmt[7:0]);
      end
      value = body[71 - 8 * k -: 8];
      running = crc8_fold(running, value, poly_shadow);
      put_byte(value, restart && k == 0, NO_TAG);
    end
    check = (kind == CHECK_GOOD) ? running : running ^ 8'($urandom_range(1, 255));
    put_byte(check, 1'b0, row_tag);
  endtask

  // Random frames are mostly well formed, with position readings pulled to
  // the interesting edges now and then. Some are preceded by noise: a burst
  // of junk bytes, long enough at times to complete a frame of its own, which
  // the next frame then drops with frame_reset.
  task automatic send_random_frame();
    logic [95:0] draw;
    logic [71:0] body;
    logic        restart;
    int          junk;
    int          k;
    draw = {$urandom(), $urandom(), $urandom()};
    body = draw[71:0];
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0: body[23:8] = 16'h0000;
        1: body[23:8] = 16'h7FFF;
        2: body[23:8] = 16'h8000;
        3: body[23:8] = 16'h8001;
        default: body[23:8] = 16'hFFFF;
      endcase
    end
    restart = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 6) == 0) begin
      junk = $urandom_range(1, 12);
      for (k = 0; k < junk; k++) begin
        put_byte(8'($urandom()), k == 0 && $urandom_range(0, 1) == 1, NO_TAG);
      end
      restart = 1'b1;
    end
    send_frame(body, ($urandom_range(0, 4) == 0) ? CHECK_BAD : CHECK_GOOD, restart,
               NO_TAG, -1, -1);
  endtask

  // Tracker: follows every accepted byte word and predicts the result word
  // that a check byte brings out.
  always @(posedge clk) begin : frame_tracker
    frame_result_t r;
    if (!rst && in_valid && in_ready) begin
      if (frame_reset) begin
        tracked_count = '0;
        tracked_crc   = 8'h00;
      end
      if (tracked_count < CHECK_INDEX) begin
        tracked_bytes[tracked_count] = rx_byte;
        tracked_crc   = crc8_fold(tracked_crc, rx_byte, poly_shadow);
        tracked_count = tracked_count + 1'b1;
      end else begin
        r.crc_ok   = (rx_byte == tracked_crc);
        r.id       = tracked_bytes[0];
        r.mode     = tracked_bytes[1];
        r.current  = {tracked_bytes[2], tracked_bytes[3]};
        r.velocity = {tracked_bytes[4], tracked_bytes[5]};
        r.position = scaled_position(fmt_shadow, tracked_bytes[6], tracked_bytes[7]);
        r.temp     = fmt_shadow ? tracked_bytes[6] : 8'h00;
        r.fault    = tracked_bytes[8];
        // Table rows may pin the verdict and the position to known values.
        if (in_tag >= 0) begin
          if (DIRECTED_FRAMES[in_tag].want_crc >= 0) begin
            r.crc_ok = DIRECTED_FRAMES[in_tag].want_crc[0];
          end
          if (DIRECTED_FRAMES[in_tag].want_pos >= 0) begin
            r.position = DIRECTED_FRAMES[in_tag].want_pos[15:0];
          end
        end
        expected_frames.push_back(r);
        tracked_count = '0;
        tracked_crc   = 8'h00;
      end
    end
  end

  // Checker: every result word taken must match the oldest prediction.
  always @(posedge clk) begin : frame_checker
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("result word with no prediction waiting");
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        compare_field("crc_ok", want.crc_ok, crc_ok);
        compare_field("motor_id", want.id, motor_id);
        compare_field("motor_mode", want.mode, motor_mode);
        compare_field("current_raw", want.current, current_raw);
        compare_field("velocity_raw", want.velocity, velocity_raw);
        compare_field("position_deg_q7", want.position, position_deg_q7);
        compare_field("temperature", want.temp, temperature);
        compare_field("fault_byte", want.fault, fault_byte);
      end
    end
  end

  // Result side: after each word it draws a stall of its own. When the
  // stimulus bumps the hold token it holds ready low for a long stretch,
  // counted here, so the frame queue fills and the input side stalls.
  always @(posedge clk) begin : result_sink
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (out_valid && out_ready) begin
        sink_gap = $urandom_range(0, sink_idle_max);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long run of cycles in which no channel moves a word means
  // the block has hung.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          row;
    int          k;
    int          phase;
    int          frames;
    int          f;
    logic [7:0]  poly_pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Writes to unmapped indexes change nothing, and the format register
    // keeps only its low bit, so the first table row still sees the reset
    // polynomial and the standard format.
    write_reg(REG_UNMAPPED_LO, 8'h5A);
    write_reg(REG_UNMAPPED_HI, 8'hA5);
    write_reg(REG_FEEDBACK_FORMAT, 8'hFE);

    for (row = 0; row < DIRECTED_COUNT; row++) begin
      if (fmt_shadow != DIRECTED_FRAMES[row].fmt) begin
        write_reg(REG_FEEDBACK_FORMAT, {7'd0, DIRECTED_FRAMES[row].fmt});
      end
      if (poly_shadow != DIRECTED_FRAMES[row].poly) begin
        write_reg(REG_CRC_POLYNOMIAL, DIRECTED_FRAMES[row].poly);
      end
      for (k = 0; k < DIRECTED_FRAMES[row].junk; k++) begin
        put_byte(8'(k * 37 + 11), 1'b0, NO_TAG);
      end
      send_frame(DIRECTED_FRAMES[row].body, DIRECTED_FRAMES[row].kind,
                 DIRECTED_FRAMES[row].junk > 0, row,
                 DIRECTED_FRAMES[row].mid_poly, DIRECTED_FRAMES[row].mid_fmt);
    end

    // Random phases, each under its own register setting and idle pattern.
    phase = 0;
    while (sent_bytes < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        write_reg(($urandom_range(0, 1) == 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  8'($urandom()));
      end
      case ($urandom_range(0, 3))
        0: poly_pick = 8'h00;
        1: poly_pick = 8'hFF;
        2: poly_pick = CRC_POLY_RESET;
        default: poly_pick = 8'($urandom());
      endcase
      write_reg(REG_CRC_POLYNOMIAL, poly_pick);
      write_reg(REG_FEEDBACK_FORMAT, 8'($urandom()));
      src_idle_max  = idle_choice();
      sink_idle_max = idle_choice();
      // The second phase pushes back-to-back bytes into a stalled output.
      if (phase == 1) begin
        src_idle_max = 0;
        hold_token <= hold_token + 1;
      end
      frames = $urandom_range(8, 16);
      for (f = 0; f < frames && sent_bytes < ITEM_TARGET; f++) begin
        // The fourth phase pauses the sender halfway until all words are out.
        if (phase == 3 && f == frames / 2) begin
          wait_drained();
        end
        send_random_frame();
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mfd_pkg.sv
src/mfd_front.sv
src/mfd_queue.sv
src/mfd_back.sv
src/motor_feedback_frame_decoder_top.sv
tb/motor_feedback_frame_decoder_top_test.sv
